// ===== rtl/mrr_pkg.sv =====
// shared types and constants for the minimal-standard random range block
package mrr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned DIV_W  = 33;
    localparam int unsigned ADDR_W = 3;

    localparam logic [14:0] MUL_A = 15'd16807;
    localparam logic [16:0] SCH_Q = 17'd127773;
    localparam logic [11:0] SCH_R = 12'd2836;

    // floor(2^47 / SCH_Q), quotient estimate is at most one short
    localparam logic [30:0] SCH_RECIP = 31'd1101465007;

    localparam logic REG_SEED = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QEST,
        ST_QREM,
        ST_QFIX,
        ST_MUL,
        ST_SUB,
        ST_MOD_START,
        ST_DIVM,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== rtl/mrr_if.sv =====
// request and result channel interfaces
interface mrr_req_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  bound_a;
    logic signed [31:0]  bound_b;

    modport source (output valid, output bound_a, output bound_b, input ready);
    modport sink   (input valid, input bound_a, input bound_b, output ready);
endinterface

interface mrr_rsp_if;
    logic                valid;
    logic                ready;
    logic signed [31:0]  value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

// ===== rtl/mrr_div.sv =====
// restoring divider, one quotient bit per cycle
module mrr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mrr_pkg::DIV_W-1:0]     i_dividend,
    input  logic [mrr_pkg::DIV_W-1:0]     i_divisor,
    output mrr_pkg::t_div_stat            o_stat,
    output logic [mrr_pkg::DIV_W-1:0]     o_remainder
);

    localparam logic [5:0] DIV_STEPS = 6'(mrr_pkg::DIV_W);

    logic [5:0]                  r_cnt;
    logic                        r_done;
    logic [mrr_pkg::DIV_W-1:0]   r_acc;
    logic [mrr_pkg::DIV_W-1:0]   r_quo;
    logic [mrr_pkg::DIV_W-1:0]   r_dvs;
    logic [mrr_pkg::DIV_W:0]     w_trial;
    logic                        w_ge;

    assign w_trial = {r_acc, r_quo[mrr_pkg::DIV_W-1]} - {1'b0, r_dvs};
    assign w_ge    = ~w_trial[mrr_pkg::DIV_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= DIV_STEPS;
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 6'd1;
                r_done <= (r_cnt == 6'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_cnt != '0) begin
            if (w_ge) begin
                r_acc <= w_trial[mrr_pkg::DIV_W-1:0];
            end else begin
                r_acc <= {r_acc[mrr_pkg::DIV_W-2:0], r_quo[mrr_pkg::DIV_W-1]};
            end
            r_quo <= {r_quo[mrr_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_stat.busy  = (r_cnt != '0);
    assign o_stat.done  = r_done;
    assign o_remainder  = r_acc;

endmodule

// ===== rtl/minstd_random_range.sv =====
// top level: minimal-standard generator returning a value between two bounds
//
// usage: write the seed register over the apb-style port (byte address 0) to
// load the generator state; it reads back the last seed written. each request
// on i_req carries bound_a and bound_b in either order, and one result on
// o_rsp carries a value between them, inclusive.
// one request is worked at a time. i_req.ready is high while the sequencer
// is idle, and the next request can be taken as soon as a result is shown.
// each request runs the schrage step (reciprocal multiply, remainder, one
// correction, products, difference) and then the modulo by the span on the
// 33-step divider, with hand-offs between them.
// the result sits in an output register, so a request is taken while an
// earlier result waits; if the receiver still stalls when the next result
// is ready, the sequencer holds until the register frees.
// reset (synchronous, active low) sets seed and state to 1 and empties the
// output register.
module minstd_random_range (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    mrr_req_if.sink                       i_req,
    mrr_rsp_if.source                     o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mrr_pkg::ADDR_W-1:0]    paddr,
    input  logic [mrr_pkg::DATA_W-1:0]    pwdata,
    output logic [mrr_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    mrr_pkg::t_state                r_state;
    mrr_pkg::t_state                n_state;

    logic [mrr_pkg::DATA_W-1:0]     r_seed;
    logic [mrr_pkg::DATA_W-1:0]     r_gen;
    logic [mrr_pkg::DATA_W-1:0]     r_lo;
    logic [mrr_pkg::DIV_W-1:0]      r_span;
    logic [15:0]                    r_q;
    logic [17:0]                    r_r;
    logic signed [33:0]             r_p1;
    logic signed [29:0]             r_p2;
    logic                           r_out_valid;
    logic [mrr_pkg::DATA_W-1:0]     r_out_value;

    logic                           w_cfg_wr;
    logic                           w_accept;
    logic                           w_out_free;
    logic                           w_out_load;
    logic                           w_div_start;
    logic [mrr_pkg::DIV_W-1:0]      w_div_dividend;
    logic [mrr_pkg::DIV_W-1:0]      w_div_divisor;
    mrr_pkg::t_div_stat             w_div_stat;
    logic [mrr_pkg::DIV_W-1:0]      w_div_rem;

    logic [mrr_pkg::DIV_W-1:0]      w_gen_ext;
    logic [mrr_pkg::DATA_W-1:0]     w_s_mag;
    logic [62:0]                    w_q_prod;
    logic [32:0]                    w_q_back;
    logic [mrr_pkg::DATA_W-1:0]     w_r_diff;
    logic                           w_r_ge_q;
    logic signed [17:0]             w_rem_s;
    logic signed [16:0]             w_quo_s;
    logic signed [33:0]             w_next;
    logic [mrr_pkg::DIV_W-1:0]      w_gm1;
    logic [mrr_pkg::DIV_W-1:0]      w_r_mag;
    logic                           w_a_le_b;
    logic [mrr_pkg::DATA_W-1:0]     w_lo;
    logic [mrr_pkg::DATA_W-1:0]     w_hi;
    logic [mrr_pkg::DIV_W-1:0]      w_span;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready & (paddr[2] == mrr_pkg::REG_SEED);
    assign prdata   = (paddr[2] == mrr_pkg::REG_SEED) ? r_seed : '0;

    // datapath terms
    assign w_gen_ext = {r_gen[31], r_gen};
    assign w_s_mag   = r_gen[31] ? (32'd0 - r_gen) : r_gen;
    // schrage quotient by reciprocal multiply, then one remainder correction
    assign w_q_prod  = w_s_mag * mrr_pkg::SCH_RECIP;
    assign w_q_back  = r_q * mrr_pkg::SCH_Q;
    assign w_r_diff  = w_s_mag - w_q_back[31:0];
    assign w_r_ge_q  = (r_r >= {1'b0, mrr_pkg::SCH_Q});
    assign w_rem_s   = r_gen[31] ? -$signed({1'b0, r_r[16:0]})
                                 :  $signed({1'b0, r_r[16:0]});
    assign w_quo_s   = r_gen[31] ? -$signed({1'b0, r_q})
                                 :  $signed({1'b0, r_q});
    assign w_next    = r_p1 - 34'(r_p2);
    assign w_gm1     = w_gen_ext - 33'd1;
    assign w_r_mag   = w_gm1[32] ? (33'd0 - w_gm1) : w_gm1;

    assign w_a_le_b  = ($signed(i_req.bound_a) <= $signed(i_req.bound_b));
    assign w_lo      = w_a_le_b ? i_req.bound_a : i_req.bound_b;
    assign w_hi      = w_a_le_b ? i_req.bound_b : i_req.bound_a;
    assign w_span    = {w_hi[31], w_hi} - {w_lo[31], w_lo} + 33'd1;

    assign w_out_free = ~r_out_valid | o_rsp.ready;

    assign w_div_dividend = w_r_mag;
    assign w_div_divisor  = r_span;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mrr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = mrr_pkg::ST_QEST;
                end
            end
            mrr_pkg::ST_QEST: begin
                n_state = mrr_pkg::ST_QREM;
            end
            mrr_pkg::ST_QREM: begin
                n_state = mrr_pkg::ST_QFIX;
            end
            mrr_pkg::ST_QFIX: begin
                n_state = mrr_pkg::ST_MUL;
            end
            mrr_pkg::ST_MUL: begin
                n_state = mrr_pkg::ST_SUB;
            end
            mrr_pkg::ST_SUB: begin
                n_state = mrr_pkg::ST_MOD_START;
            end
            mrr_pkg::ST_MOD_START: begin
                n_state = mrr_pkg::ST_DIVM;
            end
            mrr_pkg::ST_DIVM: begin
                if (w_div_stat.done) begin
                    n_state = mrr_pkg::ST_OUT;
                end
            end
            mrr_pkg::ST_OUT: begin
                if (w_out_free) begin
                    n_state = mrr_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mrr_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb begin
        i_req.ready    = 1'b0;
        w_div_start    = 1'b0;
        w_out_load     = 1'b0;
        unique case (r_state)
            mrr_pkg::ST_IDLE: begin
                i_req.ready = ~w_div_stat.busy;
            end
            mrr_pkg::ST_MOD_START: begin
                w_div_start = 1'b1;
            end
            mrr_pkg::ST_OUT: begin
                w_out_load = w_out_free;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    assign w_accept = i_req.valid & i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mrr_pkg::ST_IDLE;
            r_seed      <= 32'd1;
            r_gen       <= 32'd1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                r_seed <= pwdata;
                r_gen  <= pwdata;
            end else if (r_state == mrr_pkg::ST_SUB) begin
                r_gen <= w_next[31:0];
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_lo   <= w_lo;
            r_span <= w_span;
        end
        if (r_state == mrr_pkg::ST_QEST) begin
            r_q <= w_q_prod[62:47];
        end else if ((r_state == mrr_pkg::ST_QFIX) && w_r_ge_q) begin
            r_q <= r_q + 16'd1;
        end
        if (r_state == mrr_pkg::ST_QREM) begin
            r_r <= w_r_diff[17:0];
        end else if ((r_state == mrr_pkg::ST_QFIX) && w_r_ge_q) begin
            r_r <= r_r - {1'b0, mrr_pkg::SCH_Q};
        end
        if (r_state == mrr_pkg::ST_MUL) begin
            r_p1 <= $signed({1'b0, mrr_pkg::MUL_A}) * w_rem_s;
            r_p2 <= $signed({1'b0, mrr_pkg::SCH_R}) * w_quo_s;
        end
        if (w_out_load) begin
            r_out_value <= r_lo + w_div_rem[31:0];
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.value = r_out_value;

    mrr_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (w_div_divisor),
        .o_stat      (w_div_stat),
        .o_remainder (w_div_rem)
    );

endmodule
